[hw/rtl/swfm_pkg.sv]
// ----------------------------------------------------------------------------
// Single-wire frame master package
// Shared types, codes, frame constants and frame-building functions.
// ----------------------------------------------------------------------------
`default_nettype none

package swfm_pkg;

  // Transfer phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SEND = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_RECV = 4'b1000
  } phase_t;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Transfer status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BAD_ACK = 2'd2;
  localparam logic [1:0] ST_BAD_PAR = 2'd3;

  // Read data codes reported on errors.
  localparam logic [7:0] RD_TIMEOUT = 8'hFE;
  localparam logic [7:0] RD_BAD_ACK = 8'hFC;
  localparam logic [7:0] RD_BAD_PAR = 8'hFD;

  // Configuration register indexes.
  localparam logic CFG_TICK_DIVIDER    = 1'b0;
  localparam logic CFG_SAMPLES_PER_BIT = 1'b1;

  // Configuration reset values.
  localparam logic [7:0] TICK_DIVIDER_RST    = 8'd1;
  localparam logic [7:0] SAMPLES_PER_BIT_RST = 8'd10;

  // Fixed header bits of each frame, left-aligned in 32 bits.
  localparam logic [31:0] READ_FRAME_BASE  = 32'h4500_0000;
  localparam logic [31:0] WRITE_FRAME_BASE = 32'h4480_0000;

  // Frame and reply lengths in bits.
  localparam logic [4:0] SEND_LEN_READ  = 5'd18;
  localparam logic [4:0] SEND_LEN_WRITE = 5'd27;
  localparam logic [4:0] RECV_LEN_READ  = 5'd18;
  localparam logic [4:0] RECV_LEN_WRITE = 5'd9;

  // Nine-bit field for a byte: high nibble, inverted bit 4, low nibble.
  function automatic logic [8:0] byte_field(input logic [7:0] b);
    return {b[7:4], ~b[4], b[3:0]};
  endfunction

  // Read frame: parity of the address, then the address field.
  function automatic logic [31:0] read_frame(input logic [7:0] addr);
    return READ_FRAME_BASE | {6'd0, ^addr, 2'd0, byte_field(addr), 14'd0};
  endfunction

  // Write frame: parity of address XOR data, then address and data fields.
  function automatic logic [31:0] write_frame(input logic [7:0] addr,
                                              input logic [7:0] data);
    return WRITE_FRAME_BASE |
           {6'd0, ^(addr ^ data), 2'd0, byte_field(addr), byte_field(data), 5'd0};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/single_wire_frame_master_top.sv]
// ----------------------------------------------------------------------------
// Single-wire frame master
// Builds read and write frames, shifts them out on one wire, waits for the
// device acknowledge and samples and checks the reply, paced by tick items.
// ----------------------------------------------------------------------------
// An item in the input register has its result item computed combinationally
// and loaded into the result register when the stage advances.
// Throughput: one item per cycle while the result slot is free; the next-state
// logic is a single pass of counter compares and one shift between the two registers.
// Reset: synchronous, active low; the block comes up idle with the wire
// released, tick_divider 1 and samples_per_bit 10.
`default_nettype none

module single_wire_frame_master_top
  import swfm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // address[7:0], write_data[15:8], line_in[16]
  input  wire logic [1:0]  in_tuser,  // action[1:0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata  // line_out[0], line_drive[1], busy_res[2],
                                      // done_res[3], status[5:4], read_data[13:6]
);

  // Configuration registers.
  logic [7:0] tick_div_r;
  logic [7:0] spb_r;

  // Input register.
  logic       in_valid_r;
  logic [1:0] in_action_r;
  logic [7:0] in_addr_r;
  logic [7:0] in_wdata_r;
  logic       in_line_r;

  // Result register.
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [15:0] out_data_nxt;

  // Protocol state.
  phase_t      phase_r, phase_nxt;
  logic [7:0]  presc_r, presc_nxt;
  logic [7:0]  sample_r, sample_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [12:0] wait_r, wait_nxt;
  logic [31:0] send_r, send_nxt;
  logic [17:0] recv_r, recv_nxt;
  logic [4:0]  send_len_r, send_len_nxt;
  logic [4:0]  recv_len_r, recv_len_nxt;
  logic        is_read_r, is_read_nxt;
  logic        level_r, level_nxt;
  logic        driving_r, driving_nxt;

  logic advance;

  // The stage moves forward when it holds an item and the result slot is free.
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_div_r <= TICK_DIVIDER_RST;
      spb_r      <= SAMPLES_PER_BIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_DIVIDER:    tick_div_r <= cfg_data;
        CFG_SAMPLES_PER_BIT: spb_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_action_r <= in_tuser;
      in_addr_r   <= in_tdata[7:0];
      in_wdata_r  <= in_tdata[15:8];
      in_line_r   <= in_tdata[16];
    end
  end

  // Next state and result for the item in the input register.
  always_comb begin
    logic [7:0]  presc_inc;
    logic [7:0]  sample_inc;
    logic [4:0]  bit_inc;
    logic [12:0] wait_inc;
    logic [7:0]  half_bit;
    logic [7:0]  rx_byte;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  rdata;

    presc_inc  = presc_r + 8'd1;
    sample_inc = sample_r + 8'd1;
    bit_inc    = bit_r + 5'd1;
    wait_inc   = wait_r + 13'd1;
    half_bit   = {1'b0, spb_r[7:1]} + {7'd0, spb_r[0]};
    rx_byte    = {recv_r[8:5], recv_r[3:0]};
    done       = 1'b0;
    status     = ST_OK;
    rdata      = 8'd0;

    phase_nxt    = phase_r;
    presc_nxt    = presc_r;
    sample_nxt   = sample_r;
    bit_nxt      = bit_r;
    wait_nxt     = wait_r;
    send_nxt     = send_r;
    recv_nxt     = recv_r;
    send_len_nxt = send_len_r;
    recv_len_nxt = recv_len_r;
    is_read_nxt  = is_read_r;
    level_nxt    = level_r;
    driving_nxt  = driving_r;

    if (phase_r == PH_IDLE && (in_action_r inside {ACT_READ, ACT_WRITE})) begin
      // Start a transfer: load the frame and drive the wire high.
      if (in_action_r == ACT_READ) begin
        send_nxt     = read_frame(in_addr_r);
        send_len_nxt = SEND_LEN_READ;
        recv_len_nxt = RECV_LEN_READ;
        is_read_nxt  = 1'b1;
      end else begin
        send_nxt     = write_frame(in_addr_r, in_wdata_r);
        send_len_nxt = SEND_LEN_WRITE;
        recv_len_nxt = RECV_LEN_WRITE;
        is_read_nxt  = 1'b0;
      end
      recv_nxt    = 18'd0;
      presc_nxt   = 8'd0;
      sample_nxt  = 8'd0;
      bit_nxt     = 5'd0;
      wait_nxt    = 13'd0;
      level_nxt   = 1'b1;
      driving_nxt = 1'b1;
      phase_nxt   = PH_SEND;
    end else if (in_action_r == ACT_TICK && phase_r != PH_IDLE) begin
      presc_nxt = presc_inc;
      if (presc_inc >= tick_div_r) begin
        // One protocol step.
        presc_nxt = 8'd0;
        case (phase_r)
          PH_SEND: begin
            sample_nxt = sample_inc;
            if (sample_inc >= spb_r) begin
              sample_nxt = 8'd0;
              bit_nxt    = bit_inc;
              if (bit_inc > send_len_r) begin
                // Frame sent: release the wire and wait for the acknowledge.
                phase_nxt   = PH_WAIT;
                driving_nxt = 1'b0;
                bit_nxt     = 5'd0;
                wait_nxt    = 13'd0;
              end else begin
                send_nxt  = {send_r[30:0], send_r[31]};
                level_nxt = send_r[31];
              end
            end
          end
          PH_WAIT: begin
            wait_nxt = wait_inc;
            if (wait_inc > {spb_r, 5'd0}) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              status    = ST_TIMEOUT;
              rdata     = RD_TIMEOUT;
            end else if (!in_line_r) begin
              // Acknowledge seen: sample the reply at mid-bit.
              phase_nxt  = PH_RECV;
              sample_nxt = half_bit;
            end
          end
          PH_RECV: begin
            sample_nxt = sample_inc;
            if (sample_inc >= spb_r) begin
              sample_nxt = 8'd0;
              bit_nxt    = bit_inc;
              if (bit_inc > recv_len_r) begin
                // Reply complete: check the ack bit and, for a read, the parity.
                phase_nxt = PH_IDLE;
                bit_nxt   = 5'd0;
                done      = 1'b1;
                if (is_read_r) begin
                  if (!recv_r[11]) begin
                    status = ST_BAD_ACK;
                    rdata  = RD_BAD_ACK;
                  end else if ((^rx_byte) != recv_r[10]) begin
                    status = ST_BAD_PAR;
                    rdata  = RD_BAD_PAR;
                  end else begin
                    rdata = rx_byte;
                  end
                end else if (!recv_r[2]) begin
                  status = ST_BAD_ACK;
                  rdata  = RD_BAD_ACK;
                end
              end else begin
                recv_nxt = {recv_r[16:0], in_line_r};
              end
            end
          end
          default: ;
        endcase
      end
    end

    out_data_nxt = {2'b00, rdata, status, done, (phase_nxt != PH_IDLE),
                    driving_nxt, (driving_nxt & level_nxt)};
  end

  // Protocol state update, once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      presc_r    <= 8'd0;
      sample_r   <= 8'd0;
      bit_r      <= 5'd0;
      wait_r     <= 13'd0;
      send_r     <= 32'd0;
      recv_r     <= 18'd0;
      send_len_r <= 5'd0;
      recv_len_r <= 5'd0;
      is_read_r  <= 1'b0;
      level_r    <= 1'b1;
      driving_r  <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      presc_r    <= presc_nxt;
      sample_r   <= sample_nxt;
      bit_r      <= bit_nxt;
      wait_r     <= wait_nxt;
      send_r     <= send_nxt;
      recv_r     <= recv_nxt;
      send_len_r <= send_len_nxt;
      recv_len_r <= recv_len_nxt;
      is_read_r  <= is_read_nxt;
      level_r    <= level_nxt;
      driving_r  <= driving_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire
